### rtl/core/ptsq_pkg.sv
// shared types and constants for the pan/tilt step quantizer
package ptsq_pkg;

  // field widths
  localparam int AzW     = 26;
  localparam int ElW     = 24;
  localparam int RateW   = 32;
  localparam int IntW    = 12;
  localparam int IntMsW  = 22;
  localparam int OffW    = 32;
  localparam int StepW   = 16;
  localparam int IdxW    = 32;
  localparam int TotW    = 32;
  localparam int WrapW   = 28;
  localparam int AngW    = 25;
  localparam int MagW    = 24;
  localparam int ProdW   = MagW + RateW;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 32;

  // angle constants in 1/65536 degree
  localparam logic signed [WrapW-1:0] FullTurn    = 28'sd23592960;
  localparam logic signed [WrapW-1:0] TwoTurns    = 28'sd47185920;
  localparam logic signed [WrapW-1:0] PanHome     = 28'sd11796480;
  localparam logic signed [AngW-1:0]  TiltHome    = 25'sd2949120;
  localparam logic [9:0]              MsPerSecond = 10'd1000;

  // reset values of the registers
  localparam logic [RateW-1:0]  RateReset     = 32'd65536;
  localparam logic [IntMsW-1:0] IntervalReset = 22'd1000;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAN_RATE  = 2'd0,
    CFG_TILT_RATE = 2'd1,
    CFG_INTERVAL  = 2'd2
  } cfg_reg_e;

  // classified point as queued between front and back
  typedef struct packed {
    logic [IdxW-1:0] index;
    logic            start;
    logic            pan_neg;
    logic [MagW-1:0] pan_mag;
    logic            tilt_neg;
    logic [MagW-1:0] tilt_mag;
  } item_t;

  // queue write side
  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  // queue read side
  typedef struct packed {
    logic  valid;
    item_t item;
  } pop_t;

endpackage

### rtl/core/ptsq_if.sv
// stream and register-write channel interfaces
interface ptsq_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ptsq_pkg::AzW-1:0]     azimuth;
  logic signed [ptsq_pkg::ElW-1:0]     elevation;
  logic                                start_of_track;

  modport source (output valid, azimuth, elevation, start_of_track, input ready);
  modport sink   (input valid, azimuth, elevation, start_of_track, output ready);
endinterface

interface ptsq_out_if;
  logic                                valid;
  logic                                ready;
  logic        [ptsq_pkg::OffW-1:0]    time_ms;
  logic signed [ptsq_pkg::StepW-1:0]   pan_step;
  logic signed [ptsq_pkg::StepW-1:0]   tilt_step;

  modport source (output valid, time_ms, pan_step, tilt_step, input ready);
  modport sink   (input valid, time_ms, pan_step, tilt_step, output ready);
endinterface

interface ptsq_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ptsq_pkg::CfgIdxW-1:0]       index;
  logic [ptsq_pkg::CfgDatW-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/ptsq_front.sv
// front part: accepts points, numbers them and folds angles into sign and magnitude
module ptsq_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  ptsq_in_if.sink          in_i,
  input  logic             full_i,
  output ptsq_pkg::push_t  push_o
);

  logic [ptsq_pkg::IdxW-1:0]         index_q, index_d;
  logic [ptsq_pkg::IdxW-1:0]         cur_index;
  logic                              accept;
  logic signed [ptsq_pkg::WrapW-1:0] az_shift, az_wrap;
  logic signed [ptsq_pkg::WrapW-1:0] pan_wide;
  logic signed [ptsq_pkg::AngW-1:0]  pan_angle, tilt_angle, pan_abs, tilt_abs;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  // point index, cleared by the start flag
  assign cur_index = in_i.start_of_track ? '0 : index_q;
  assign index_d   = accept ? cur_index + ptsq_pkg::IdxW'(1) : index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q <= '0;
    end else begin
      index_q <= index_d;
    end
  end

  // floor modulo of azimuth plus a turn, then measured from pan home
  always_comb begin
    az_shift = ptsq_pkg::WrapW'(in_i.azimuth) + ptsq_pkg::FullTurn;
    if (az_shift < 0) begin
      az_wrap = az_shift + ptsq_pkg::FullTurn;
    end else if (az_shift >= ptsq_pkg::TwoTurns) begin
      az_wrap = az_shift - ptsq_pkg::TwoTurns;
    end else if (az_shift >= ptsq_pkg::FullTurn) begin
      az_wrap = az_shift - ptsq_pkg::FullTurn;
    end else begin
      az_wrap = az_shift;
    end
    pan_wide  = az_wrap - ptsq_pkg::PanHome;
    pan_angle = pan_wide[ptsq_pkg::AngW-1:0];
  end

  // tilt measured from tilt home
  assign tilt_angle = ptsq_pkg::AngW'(in_i.elevation) - ptsq_pkg::TiltHome;

  // sign and magnitude
  assign pan_abs  = pan_angle[ptsq_pkg::AngW-1] ? -pan_angle : pan_angle;
  assign tilt_abs = tilt_angle[ptsq_pkg::AngW-1] ? -tilt_angle : tilt_angle;

  always_comb begin
    push_o.valid         = accept;
    push_o.item.index    = cur_index;
    push_o.item.start    = in_i.start_of_track;
    push_o.item.pan_neg  = pan_angle[ptsq_pkg::AngW-1];
    push_o.item.pan_mag  = pan_abs[ptsq_pkg::MagW-1:0];
    push_o.item.tilt_neg = tilt_angle[ptsq_pkg::AngW-1];
    push_o.item.tilt_mag = tilt_abs[ptsq_pkg::MagW-1:0];
  end

endmodule

### rtl/core/ptsq_fifo.sv
// short queue of classified points between front and back
module ptsq_fifo #(
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ptsq_pkg::push_t  push_i,
  output logic             full_o,
  input  logic             pop_i,
  output ptsq_pkg::pop_t   pop_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ptsq_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && (count_q != '0);

  // pointers wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

  assign pop_o.valid = (count_q != '0);
  assign pop_o.item  = mem_q[rd_ptr_q];

endmodule

### rtl/core/ptsq_back.sv
// back part: scales, rounds and turns targets into step increments
module ptsq_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ptsq_pkg::pop_t                    pop_i,
  output logic                              pop_o,
  input  logic [ptsq_pkg::RateW-1:0]        pan_rate_i,
  input  logic [ptsq_pkg::RateW-1:0]        tilt_rate_i,
  input  logic [ptsq_pkg::IntMsW-1:0]       interval_ms_i,
  ptsq_out_if.source                        out_o
);

  localparam int OffProdW = ptsq_pkg::IdxW + ptsq_pkg::IntMsW;
  localparam int SumW     = ptsq_pkg::ProdW + 1;
  localparam int RndW     = SumW - 32;

  logic advance;

  // stage 1: products
  logic                             s1_valid_q;
  logic                             s1_start_q, s1_pan_neg_q, s1_tilt_neg_q;
  logic [ptsq_pkg::ProdW-1:0]       s1_pan_prod_q, s1_tilt_prod_q;
  logic [ptsq_pkg::OffW-1:0]        s1_offset_q;
  logic [OffProdW-1:0]              offset_prod;

  // stage 2: rounded targets
  logic                             s2_valid_q, s2_start_q;
  logic [ptsq_pkg::TotW-1:0]        s2_pan_tgt_q, s2_tilt_tgt_q;
  logic [ptsq_pkg::TotW-1:0]        pan_tgt_d, tilt_tgt_d;
  logic [SumW-1:0]                  pan_sum, tilt_sum;
  logic [RndW-1:0]                  pan_rnd, tilt_rnd;
  logic [ptsq_pkg::OffW-1:0]        s2_offset_q;

  // output stage and executed totals
  logic                             out_valid_q;
  logic [ptsq_pkg::OffW-1:0]        out_offset_q;
  logic [ptsq_pkg::StepW-1:0]       out_pan_q, out_tilt_q;
  logic [ptsq_pkg::TotW-1:0]        exec_pan_q, exec_pan_d, exec_tilt_q, exec_tilt_d;
  logic [ptsq_pkg::TotW-1:0]        pan_base, tilt_base, pan_diff, tilt_diff;

  // whole pipeline moves when the output word is free or being taken
  assign advance = !out_valid_q || out_o.ready;
  assign pop_o   = advance;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= pop_i.valid;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // stage 1: magnitude times rate, index times interval in ms
  assign offset_prod = OffProdW'(pop_i.item.index) * OffProdW'(interval_ms_i);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_start_q     <= pop_i.item.start;
      s1_pan_neg_q   <= pop_i.item.pan_neg;
      s1_tilt_neg_q  <= pop_i.item.tilt_neg;
      s1_pan_prod_q  <= ptsq_pkg::ProdW'(pop_i.item.pan_mag) * ptsq_pkg::ProdW'(pan_rate_i);
      s1_tilt_prod_q <= ptsq_pkg::ProdW'(pop_i.item.tilt_mag) * ptsq_pkg::ProdW'(tilt_rate_i);
      s1_offset_q    <= offset_prod[ptsq_pkg::OffW-1:0];
    end
  end

  // stage 2: round half away from zero and restore the sign
  always_comb begin
    pan_sum    = SumW'(s1_pan_prod_q) + (SumW'(1) << 31);
    tilt_sum   = SumW'(s1_tilt_prod_q) + (SumW'(1) << 31);
    pan_rnd    = pan_sum[SumW-1:32];
    tilt_rnd   = tilt_sum[SumW-1:32];
    pan_tgt_d  = s1_pan_neg_q ? ptsq_pkg::TotW'(0) - ptsq_pkg::TotW'(pan_rnd)
                              : ptsq_pkg::TotW'(pan_rnd);
    tilt_tgt_d = s1_tilt_neg_q ? ptsq_pkg::TotW'(0) - ptsq_pkg::TotW'(tilt_rnd)
                               : ptsq_pkg::TotW'(tilt_rnd);
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_start_q    <= s1_start_q;
      s2_pan_tgt_q  <= pan_tgt_d;
      s2_tilt_tgt_q <= tilt_tgt_d;
      s2_offset_q   <= s1_offset_q;
    end
  end

  // stage 3: increment against the executed total, total follows the truncated step
  always_comb begin
    pan_base    = s2_start_q ? '0 : exec_pan_q;
    tilt_base   = s2_start_q ? '0 : exec_tilt_q;
    pan_diff    = s2_pan_tgt_q - pan_base;
    tilt_diff   = s2_tilt_tgt_q - tilt_base;
    exec_pan_d  = pan_base + {{(ptsq_pkg::TotW - ptsq_pkg::StepW){pan_diff[ptsq_pkg::StepW-1]}},
                              pan_diff[ptsq_pkg::StepW-1:0]};
    exec_tilt_d = tilt_base + {{(ptsq_pkg::TotW - ptsq_pkg::StepW){tilt_diff[ptsq_pkg::StepW-1]}},
                               tilt_diff[ptsq_pkg::StepW-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_pan_q  <= '0;
      exec_tilt_q <= '0;
    end else if (advance && s2_valid_q) begin
      exec_pan_q  <= exec_pan_d;
      exec_tilt_q <= exec_tilt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_offset_q <= s2_offset_q;
      out_pan_q    <= pan_diff[ptsq_pkg::StepW-1:0];
      out_tilt_q   <= tilt_diff[ptsq_pkg::StepW-1:0];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.time_ms   = out_offset_q;
  assign out_o.pan_step  = out_pan_q;
  assign out_o.tilt_step = out_tilt_q;

endmodule

### rtl/core/pan_tilt_step_quantizer_core.sv
// top level of the pan/tilt step quantizer
// Takes one trajectory point per word and returns one word with the time offset in ms and
// signed 16-bit pan and tilt step increments. A word is accepted every cycle while the point
// queue has room; results come out in order, each passing from the point queue through the back
// stages, and one result per cycle is sustained as long as the output side takes them. The
// rate is set by the executed-total update in the last back stage. Points wait in a queue of
// FifoDepth words, so the input keeps accepting while the output is stalled until the queue
// fills. Register writes are taken every cycle; the interval register stores seconds already
// scaled to ms.
module pan_tilt_step_quantizer_core #(
  parameter int FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptsq_in_if.sink    in_i,
  ptsq_out_if.source out_o,
  ptsq_cfg_if.sink   cfg_i
);

  logic [ptsq_pkg::RateW-1:0]  pan_rate_q, tilt_rate_q;
  logic [ptsq_pkg::IntMsW-1:0] interval_ms_q, interval_ms_d;
  ptsq_pkg::push_t             push;
  ptsq_pkg::pop_t              pop_word;
  logic                        full, pop;

  // register writes
  assign cfg_i.ready   = 1'b1;
  assign interval_ms_d = ptsq_pkg::IntMsW'(cfg_i.data[ptsq_pkg::IntW-1:0])
                       * ptsq_pkg::IntMsW'(ptsq_pkg::MsPerSecond);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_rate_q    <= ptsq_pkg::RateReset;
      tilt_rate_q   <= ptsq_pkg::RateReset;
      interval_ms_q <= ptsq_pkg::IntervalReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        ptsq_pkg::CFG_PAN_RATE:  pan_rate_q    <= cfg_i.data;
        ptsq_pkg::CFG_TILT_RATE: tilt_rate_q   <= cfg_i.data;
        ptsq_pkg::CFG_INTERVAL:  interval_ms_q <= interval_ms_d;
        default: ;
      endcase
    end
  end

  ptsq_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push)
  );

  ptsq_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .pop_i  (pop),
    .pop_o  (pop_word)
  );

  ptsq_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_i         (pop_word),
    .pop_o         (pop),
    .pan_rate_i    (pan_rate_q),
    .tilt_rate_i   (tilt_rate_q),
    .interval_ms_i (interval_ms_q),
    .out_o         (out_o)
  );

endmodule

### rtl/core/ptsq_checker.sv
// port-level checks for the step quantizer and their binding
module ptsq_checker #(
  parameter int FifoDepth = 4
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [ptsq_pkg::OffW-1:0]         out_offset_i,
  input logic signed [ptsq_pkg::StepW-1:0] out_pan_i,
  input logic signed [ptsq_pkg::StepW-1:0] out_tilt_i
);

  localparam int MaxInFlight = FifoDepth + 3;
  localparam int FlightW     = $clog2(MaxInFlight + 2);

  logic               in_acc, out_acc;
  logic [FlightW-1:0] flight_q, flight_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // points accepted but not yet delivered
  always_comb begin
    flight_d = flight_q;
    if (in_acc && !out_acc) begin
      flight_d = flight_q + FlightW'(1);
    end else if (out_acc && !in_acc) begin
      flight_d = flight_q - FlightW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q <= '0;
    end else begin
      flight_q <= flight_d;
    end
  end

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_offset_i) && $stable(out_pan_i) && $stable(out_tilt_i))
    else $error("result word changed while stalled");

  // no result without a point behind it
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> flight_q != '0)
    else $error("result word delivered with no point in flight");

  // storage bound: queue plus pipeline stages
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flight_q <= FlightW'(MaxInFlight))
    else $error("more points in flight than the design can hold");

endmodule

bind pan_tilt_step_quantizer_core ptsq_checker #(
  .FifoDepth (FifoDepth)
) u_ptsq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_offset_i (out_o.time_ms),
  .out_pan_i    (out_o.pan_step),
  .out_tilt_i   (out_o.tilt_step)
);
